// ===== sv/cphs_pkg.sv =====
// ----------------------------------------------------------------------------
// Coprime hop step search: shared definitions
// Widths, ratio constants, state types and the request and response records
// exchanged between the search sequencer and its serial units.
// ----------------------------------------------------------------------------
package cphs_pkg;

	localparam int CountW   = 8;
	localparam int BitCntW  = $clog2(CountW);
	localparam int RatioNum = 618;
	localparam int RatioDen = 1000;
	localparam int ProdW    = 18;
	localparam int ProdCntW = $clog2(ProdW);
	localparam int RemW     = 10;

	typedef logic [CountW-1:0] count_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCALE,
		S_UP,
		S_UP_GCD,
		S_DOWN,
		S_DOWN_GCD,
		S_NEXT,
		S_FINISH
	} search_state_t;

	typedef enum logic [1:0] {
		G_IDLE,
		G_TEST,
		G_DIV
	} gcd_state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_RUN,
		SC_DONE
	} scale_state_t;

	typedef struct packed {
		logic   start;
		count_t cand;
		count_t n;
	} gcd_req_t;

	typedef struct packed {
		logic done;
		logic coprime;
	} gcd_rsp_t;

	typedef struct packed {
		logic   done;
		count_t target;
	} scale_rsp_t;

endpackage

// ===== sv/cphs_scale.sv =====
// ----------------------------------------------------------------------------
// Coprime hop step search: start point unit
// Forms N*618 and divides it by 1000 one quotient bit per cycle with a
// restoring divider, then substitutes N/2 when the quotient is below two.
// ----------------------------------------------------------------------------
module cphs_scale import cphs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  count_t     n,
	output scale_rsp_t rsp
);

	scale_state_t          state_q;
	scale_state_t          state_d;
	logic [ProdW-1:0]      sh_q;
	logic [RemW-1:0]       rem_q;
	count_t                quo_q;
	count_t                n_q;
	logic [ProdCntW-1:0]   cnt_q;
	logic [RemW:0]         rem_ext;
	logic                  ge;
	logic [RemW-1:0]       rem_new;
	logic                  last;

	assign rem_ext = {rem_q, sh_q[ProdW-1]};
	assign ge      = rem_ext >= (RemW+1)'(RatioDen);
	assign rem_new = ge ? RemW'(rem_ext - (RemW+1)'(RatioDen)) : rem_ext[RemW-1:0];
	assign last    = cnt_q == ProdCntW'(ProdW - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SC_IDLE: if (start) state_d = SC_RUN;
			SC_RUN:  if (last) state_d = SC_DONE;
			SC_DONE: state_d = SC_IDLE;
			default: state_d = SC_IDLE;
		endcase
	end

	always_comb begin
		rsp.done   = 1'b0;
		rsp.target = quo_q;
		unique case (state_q)
			SC_DONE: begin
				rsp.done = 1'b1;
				if (quo_q < count_t'(2)) begin
					rsp.target = n_q >> 1;
				end
			end
			default: rsp.done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SC_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == SC_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SC_IDLE && start) begin
			n_q   <= n;
			sh_q  <= ProdW'(n * RatioNum);
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == SC_RUN) begin
			sh_q  <= sh_q << 1;
			rem_q <= rem_new;
			quo_q <= {quo_q[CountW-2:0], ge};
		end
	end

endmodule

// ===== sv/cphs_gcd.sv =====
// ----------------------------------------------------------------------------
// Coprime hop step search: serial Euclid unit
// Runs Euclid's remainder loop on a candidate and N, each remainder taken by
// a restoring divider that consumes one dividend bit per cycle.
// ----------------------------------------------------------------------------
module cphs_gcd import cphs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  gcd_req_t req,
	output gcd_rsp_t rsp
);

	gcd_state_t          state_q;
	gcd_state_t          state_d;
	count_t              x_q;
	count_t              y_q;
	count_t              rem_q;
	count_t              sh_q;
	logic [BitCntW-1:0]  cnt_q;
	logic [CountW:0]     rem_ext;
	logic                ge;
	count_t              rem_new;
	logic                last;

	assign rem_ext = {rem_q, sh_q[CountW-1]};
	assign ge      = rem_ext >= {1'b0, y_q};
	assign rem_new = ge ? CountW'(rem_ext - {1'b0, y_q}) : rem_ext[CountW-1:0];
	assign last    = cnt_q == BitCntW'(CountW - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			G_IDLE: if (req.start) state_d = G_TEST;
			G_TEST: state_d = (y_q == '0) ? G_IDLE : G_DIV;
			G_DIV:  if (last) state_d = G_TEST;
			default: state_d = G_IDLE;
		endcase
	end

	always_comb begin
		rsp.done    = 1'b0;
		rsp.coprime = x_q == count_t'(1);
		unique case (state_q)
			G_TEST:  rsp.done = y_q == '0;
			default: rsp.done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == G_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			G_IDLE: begin
				if (req.start) begin
					x_q <= req.cand;
					y_q <= req.n;
				end
			end
			G_TEST: begin
				sh_q  <= x_q;
				rem_q <= '0;
			end
			G_DIV: begin
				sh_q  <= sh_q << 1;
				rem_q <= rem_new;
				if (last) begin
					x_q <= y_q;
					y_q <= rem_new;
				end
			end
			default: begin
				sh_q <= sh_q;
			end
		endcase
	end

endmodule

// ===== sv/coprime_hop_step_search_top.sv =====
// ----------------------------------------------------------------------------
// Coprime hop step search: top level
// Returns a hop step coprime to the channel count, searched outwards from
// about 0.618 times the count.
// ----------------------------------------------------------------------------
// One item is in work at a time. A channel count of zero or one skips the
// search. Otherwise the start point unit runs first, and each candidate
// then costs bookkeeping states plus one gcd, which runs one serial
// division for every Euclid remainder step. Up to 2N candidates may be
// tried. The serial divider inside the gcd unit sets the pace. A finished
// result sits in an output register, and the next channel count can be
// taken while it waits for its transfer.
module coprime_hop_step_search_top import cphs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  count_t channel_count,
	output logic   out_valid,
	input  logic   out_ready,
	output count_t hop_step
);

	search_state_t state_q;
	search_state_t state_d;
	count_t        n_q;
	count_t        target_q;
	count_t        off_q;
	count_t        cand_q;
	count_t        result_q;
	count_t        hop_step_q;
	logic          out_valid_q;

	logic          accept;
	logic          scale_start;
	scale_rsp_t    scale_rsp;
	gcd_req_t      gcd_req;
	gcd_rsp_t      gcd_rsp;
	logic          load;
	logic [CountW:0] up_sum;
	count_t        down_val;
	logic          up_ok;
	logic          down_ok;
	logic          off_last;

	assign up_sum   = {1'b0, target_q} + {1'b0, off_q};
	assign up_ok    = up_sum < {1'b0, n_q};
	assign down_val = target_q - off_q;
	assign down_ok  = (target_q >= off_q) && (down_val > count_t'(1));
	assign off_last = ({1'b0, off_q} + 1'b1) == {1'b0, n_q};
	assign accept   = in_valid && in_ready;

	cphs_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.n      (channel_count),
		.rsp    (scale_rsp)
	);

	cphs_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (gcd_req),
		.rsp    (gcd_rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (channel_count <= count_t'(1)) ? S_FINISH : S_SCALE;
				end
			end
			S_SCALE:    if (scale_rsp.done) state_d = S_UP;
			S_UP:       state_d = up_ok ? S_UP_GCD : S_DOWN;
			S_UP_GCD:   if (gcd_rsp.done) state_d = gcd_rsp.coprime ? S_FINISH : S_DOWN;
			S_DOWN:     state_d = down_ok ? S_DOWN_GCD : S_NEXT;
			S_DOWN_GCD: if (gcd_rsp.done) state_d = gcd_rsp.coprime ? S_FINISH : S_NEXT;
			S_NEXT:     state_d = off_last ? S_FINISH : S_UP;
			S_FINISH:   if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		scale_start   = 1'b0;
		gcd_req.start = 1'b0;
		gcd_req.cand  = up_sum[CountW-1:0];
		gcd_req.n     = n_q;
		load          = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				scale_start = in_valid && (channel_count > count_t'(1));
			end
			S_UP: gcd_req.start = up_ok;
			S_DOWN: begin
				gcd_req.start = down_ok;
				gcd_req.cand  = down_val;
			end
			S_FINISH: load = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q      <= channel_count;
			result_q <= count_t'(1);
		end
		if (state_q == S_SCALE && scale_rsp.done) begin
			target_q <= scale_rsp.target;
			off_q    <= '0;
		end
		if (gcd_req.start) begin
			cand_q <= gcd_req.cand;
		end
		if ((state_q == S_UP_GCD || state_q == S_DOWN_GCD) && gcd_rsp.done
				&& gcd_rsp.coprime) begin
			result_q <= cand_q;
		end
		if (state_q == S_NEXT) begin
			if (off_last) begin
				result_q <= count_t'(1);
			end else begin
				off_q <= off_q + 1'b1;
			end
		end
		if (load) begin
			hop_step_q <= result_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hop_step  = hop_step_q;

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hop_step != '0)
		else $error("hop step of zero offered");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP || state_q == S_DOWN) |-> off_q < n_q)
		else $error("search offset reached the channel count");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted channel count left the sequencer idle");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid && hop_step == $past(result_q))
		else $error("finished result not presented");

endmodule
